@@ rtl/core/bms_pkg.sv @@
// Shared types and constants of the box matcher and smoother.
// Holds the box record, the sequencer states and the score unit's transfer records.
// No dependencies.
package bms_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int SLOT_W      = 6;
    localparam int PADDR_W     = 4;

    localparam logic [16:0] ALPHA_ONE   = 17'd65536;
    localparam logic [16:0] ALPHA_RESET = 17'd45875;
    localparam logic [30:0] DIST_RESET  = 31'd32768;
    localparam logic [16:0] SIZE_RESET  = 17'd19661;

    typedef enum logic [1:0] {
        REG_BLEND_ALPHA = 2'd0,
        REG_DIST_LIMIT  = 2'd1,
        REG_SIZE_LIMIT  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [23:0]        ez;
        logic [23:0]        ey;
        logic [23:0]        ex;
        logic signed [31:0] cz;
        logic signed [31:0] cy;
        logic signed [31:0] cx;
    } box_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SQ,
        ST_START,
        ST_ROOT,
        ST_CHECK,
        ST_BREAD,
        ST_BMUL,
        ST_BACC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [63:0]     sq_sum;
        logic [2:0][23:0] num;
        logic [2:0][23:0] den;
    } score_in_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
        logic [18:0] rel_sum;
    } score_out_t;

    // Axis 0..2 are centers, 3..5 are extents, all widened to 33 bits signed.
    function automatic logic signed [32:0] box_axis(box_t b, logic [2:0] k);
        logic signed [32:0] v;
        unique case (k)
            3'd0:    v = {b.cx[31], b.cx};
            3'd1:    v = {b.cy[31], b.cy};
            3'd2:    v = {b.cz[31], b.cz};
            3'd3:    v = {9'd0, b.ex};
            3'd4:    v = {9'd0, b.ey};
            3'd5:    v = {9'd0, b.ez};
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic box_t box_set_axis(box_t b, logic [2:0] k, logic [31:0] v);
        box_t r;
        r = b;
        unique case (k)
            3'd0:    r.cx = v;
            3'd1:    r.cy = v;
            3'd2:    r.cz = v;
            3'd3:    r.ex = v[23:0];
            3'd4:    r.ey = v[23:0];
            3'd5:    r.ez = v[23:0];
            default: r = b;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/bms_score_unit.sv @@
// Iterative square root and three relative size dividers, one bit per cycle.
// Depends on bms_pkg for the score_in_t and score_out_t records.
module bms_score_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  bms_pkg::score_in_t  op,
    output bms_pkg::score_out_t res
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg;
    logic [63:0] v_reg, v_next;
    logic [63:0] r_reg, r_next;
    logic [63:0] bit_reg;
    logic [2:0][24:0] dr_reg, dr_next;
    logic [2:0][16:0] q_reg, q_next;
    logic [2:0][23:0] den_reg;

    logic [63:0] trial;
    logic [24:0] shifted;
    logic [2:0][16:0] rel;

    always_comb begin
        trial = r_reg + bit_reg;
        if (v_reg >= trial) begin
            v_next = v_reg - trial;
            r_next = (r_reg >> 1) + bit_reg;
        end else begin
            v_next = v_reg;
            r_next = r_reg >> 1;
        end
        dr_next = dr_reg;
        q_next  = q_reg;
        shifted = '0;
        for (int k = 0; k < 3; k++) begin
            shifted = (cnt_reg == 5'd0) ? dr_reg[k] : {dr_reg[k][23:0], 1'b0};
            if (cnt_reg <= 5'd16) begin
                if (shifted >= {1'b0, den_reg[k]}) begin
                    dr_next[k] = shifted - {1'b0, den_reg[k]};
                    q_next[k]  = {q_reg[k][15:0], 1'b1};
                end else begin
                    dr_next[k] = shifted;
                    q_next[k]  = {q_reg[k][15:0], 1'b0};
                end
            end
        end
        busy_next = busy_reg && (cnt_reg != 5'd31);
        done_next = busy_reg && (cnt_reg == 5'd31);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg   <= op.sq_sum;
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
            for (int k = 0; k < 3; k++) begin
                dr_reg[k]  <= {1'b0, op.num[k]};
                q_reg[k]   <= '0;
                den_reg[k] <= op.den[k];
            end
        end else if (busy_reg) begin
            v_reg   <= v_next;
            r_reg   <= r_next;
            bit_reg <= bit_reg >> 2;
            dr_reg  <= dr_next;
            q_reg   <= q_next;
        end
    end

    // zero when both sizes are zero
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rel[k] = (den_reg[k] == 24'd0) ? 17'd0 : q_reg[k];
        end
        res.done    = done_reg;
        res.root    = r_reg[31:0];
        res.rel_sum = {2'b0, rel[0]} + {2'b0, rel[1]} + {2'b0, rel[2]};
    end

endmodule

@@ rtl/core/box_match_and_ema_smoother.sv @@
// Top level of the 3-D box matcher with exponential smoothing.
// Depends on bms_pkg and bms_score_unit.
//
//  channel   dir  handshake         payload
//  s_*       in   s_tvalid/tready   s_tdata boxes, s_tuser has_box, s_tlast frame end
//  m_*       out  m_tvalid/tready   m_tdata box + slot, m_tuser flags, m_tlast frame end
//  apb       in   psel/penable      three registers at byte addresses 0, 4, 8
//
// When the previous frame is empty, an item goes from idle straight to done. Otherwise
// each stored box is pruned by axis delta after a read and a load, or is fully scored
// through the 32-step square root in bms_score_unit. A match then blends all six axes
// on the single shared multiplier. s_tready is high only in idle; a result waits in the
// output register while the next transaction is accepted. Reset is synchronous and
// clears counts, bank select, registers and the sequencer; the stores need no clearing.
module box_match_and_ema_smoother (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bms_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // center_x, center_y, center_z, extent_x, extent_y, extent_z
    input  logic [167:0]                  s_tdata,
    // has_box
    input  logic                          s_tuser,
    input  logic                          s_tlast,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_center_x/y/z, out_extent_x/y/z, match_slot, two zero bits
    output logic [175:0]                  m_tdata,
    // matched, kept
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);

    localparam logic [bms_pkg::CNT_W-1:0] DEPTH_C = bms_pkg::CNT_W'(bms_pkg::STORE_DEPTH);

    bms_pkg::state_t state_reg, state_next;

    // configuration
    logic [16:0] alpha_reg;
    logic [30:0] dist_lim_reg;
    logic [16:0] size_lim_reg;
    logic        cfg_wr;

    // frame bookkeeping
    logic [bms_pkg::CNT_W-1:0] prev_cnt_reg, build_cnt_reg;
    logic                      bank_reg;

    // item and scan state
    bms_pkg::box_t              in_box_reg, res_box_reg;
    logic                       fend_reg;
    logic [bms_pkg::CNT_W-1:0]  idx_reg;
    logic                       found_reg;
    logic [34:0]                best_reg;
    logic [bms_pkg::IDX_W-1:0]  slot_reg;
    logic [2:0][30:0]           dsq_reg;
    logic [1:0]                 sq_cnt_reg;
    logic [63:0]                acc_reg;
    logic [2:0]                 axis_reg;
    bms_pkg::score_in_t         sc_in_reg;
    bms_pkg::score_out_t        sc_out;

    // store
    bms_pkg::box_t              mem [0:2*bms_pkg::STORE_DEPTH-1];
    bms_pkg::box_t              mem_q_reg;
    logic                       rd_en;
    logic [bms_pkg::ADDR_W-1:0] rd_addr;
    logic                       wr_en;
    logic [bms_pkg::ADDR_W-1:0] wr_addr;

    // shared multiplier
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod_reg;

    // output register
    logic          m_valid_reg;
    bms_pkg::box_t m_box_reg;
    logic [5:0]    m_slot_reg;
    logic          m_matched_reg, m_kept_reg, m_last_reg;

    logic s_acc, sc_start, out_free, last_entry, kept, entry_pruned, entry_ok;
    logic [2:0][33:0] cdiff, cabs;
    logic signed [32:0] cmp_cur, cmp_prev;
    logic [2:0][23:0] ext_num, ext_den;
    logic [16:0]      alpha_eff;
    logic [18:0]      size3;
    logic [34:0]      score;
    logic signed [67:0] blend_t;
    logic signed [32:0] cur_ax, prev_ax;

    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign kept     = build_cnt_reg < DEPTH_C;
    assign last_entry = (idx_reg + 1'b1) >= prev_cnt_reg;
    assign alpha_eff  = (alpha_reg > bms_pkg::ALPHA_ONE) ? bms_pkg::ALPHA_ONE : alpha_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg    <= bms_pkg::ALPHA_RESET;
            dist_lim_reg <= bms_pkg::DIST_RESET;
            size_lim_reg <= bms_pkg::SIZE_RESET;
        end else if (cfg_wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                bms_pkg::REG_BLEND_ALPHA: alpha_reg    <= pwdata[16:0];
                bms_pkg::REG_DIST_LIMIT:  dist_lim_reg <= pwdata[30:0];
                bms_pkg::REG_SIZE_LIMIT:  size_lim_reg <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            bms_pkg::REG_BLEND_ALPHA: prdata = {15'd0, alpha_reg};
            bms_pkg::REG_DIST_LIMIT:  prdata = {1'b0, dist_lim_reg};
            bms_pkg::REG_SIZE_LIMIT:  prdata = {15'd0, size_lim_reg};
            default:                  prdata = '0;
        endcase
    end

    // ---------------- per-entry compare against the stored box ----------------
    always_comb begin
        cmp_cur  = '0;
        cmp_prev = '0;
        for (int k = 0; k < 3; k++) begin
            cmp_cur  = bms_pkg::box_axis(in_box_reg, 3'(k));
            cmp_prev = bms_pkg::box_axis(mem_q_reg, 3'(k));
            cdiff[k] = {cmp_cur[32], cmp_cur} - {cmp_prev[32], cmp_prev};
            cabs[k]  = cdiff[k][33] ? -cdiff[k] : cdiff[k];
        end
        entry_pruned = (cabs[0] > {3'd0, dist_lim_reg}) || (cabs[1] > {3'd0, dist_lim_reg})
                    || (cabs[2] > {3'd0, dist_lim_reg});
        ext_num[0] = (in_box_reg.ex > mem_q_reg.ex) ? in_box_reg.ex - mem_q_reg.ex
                                                    : mem_q_reg.ex - in_box_reg.ex;
        ext_den[0] = (in_box_reg.ex > mem_q_reg.ex) ? in_box_reg.ex : mem_q_reg.ex;
        ext_num[1] = (in_box_reg.ey > mem_q_reg.ey) ? in_box_reg.ey - mem_q_reg.ey
                                                    : mem_q_reg.ey - in_box_reg.ey;
        ext_den[1] = (in_box_reg.ey > mem_q_reg.ey) ? in_box_reg.ey : mem_q_reg.ey;
        ext_num[2] = (in_box_reg.ez > mem_q_reg.ez) ? in_box_reg.ez - mem_q_reg.ez
                                                    : mem_q_reg.ez - in_box_reg.ez;
        ext_den[2] = (in_box_reg.ez > mem_q_reg.ez) ? in_box_reg.ez : mem_q_reg.ez;
    end

    // score = 6*dist + sum of relative differences
    assign size3 = {2'b0, size_lim_reg} + {1'b0, size_lim_reg, 1'b0};
    assign score = {1'b0, sc_out.root, 2'b0} + {2'b0, sc_out.root, 1'b0}
                 + {16'd0, sc_out.rel_sum};
    assign entry_ok = (sc_out.root <= {1'b0, dist_lim_reg}) && (sc_out.rel_sum <= size3);

    bms_score_unit u_score (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sc_start),
        .op      (sc_in_reg),
        .res     (sc_out)
    );

    // ---------------- shared multiplier ----------------
    assign cur_ax  = bms_pkg::box_axis(in_box_reg, axis_reg);
    assign prev_ax = bms_pkg::box_axis(mem_q_reg, axis_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == bms_pkg::ST_BMUL) begin
            mul_a = {17'd0, alpha_eff};
            mul_b = {prev_ax[32], prev_ax} - {cur_ax[32], cur_ax};
        end else begin
            unique case (sq_cnt_reg)
                2'd0:    mul_a = {3'd0, dsq_reg[0]};
                2'd1:    mul_a = {3'd0, dsq_reg[1]};
                2'd2:    mul_a = {3'd0, dsq_reg[2]};
                default: mul_a = '0;
            endcase
            mul_b = mul_a;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // rewrite cur*65536 + alpha*(prev-cur) + half, then floor by arithmetic shift
    assign blend_t = ({{35{cur_ax[32]}}, cur_ax} <<< 16) + prod_reg + 68'sd32768;

    // ---------------- store ----------------
    assign wr_en   = (state_reg == bms_pkg::ST_DONE) && out_free && kept;
    assign wr_addr = {~bank_reg, build_cnt_reg[bms_pkg::IDX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= res_box_reg;
        end
        if (rd_en) begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bms_pkg::ST_IDLE: begin
                if (s_acc && s_tuser) begin
                    state_next = (prev_cnt_reg == '0) ? bms_pkg::ST_DONE : bms_pkg::ST_READ;
                end
            end
            bms_pkg::ST_READ:  state_next = bms_pkg::ST_LOAD;
            bms_pkg::ST_LOAD: begin
                if (!entry_pruned) begin
                    state_next = bms_pkg::ST_SQ;
                end else if (!last_entry) begin
                    state_next = bms_pkg::ST_READ;
                end else begin
                    state_next = found_reg ? bms_pkg::ST_BREAD : bms_pkg::ST_DONE;
                end
            end
            bms_pkg::ST_SQ: begin
                if (sq_cnt_reg == 2'd3) begin
                    state_next = bms_pkg::ST_START;
                end
            end
            bms_pkg::ST_START: state_next = bms_pkg::ST_ROOT;
            bms_pkg::ST_ROOT: begin
                if (sc_out.done) begin
                    state_next = bms_pkg::ST_CHECK;
                end
            end
            bms_pkg::ST_CHECK: begin
                if (!last_entry) begin
                    state_next = bms_pkg::ST_READ;
                end else if (found_reg || entry_ok) begin
                    state_next = bms_pkg::ST_BREAD;
                end else begin
                    state_next = bms_pkg::ST_DONE;
                end
            end
            bms_pkg::ST_BREAD: state_next = bms_pkg::ST_BMUL;
            bms_pkg::ST_BMUL:  state_next = bms_pkg::ST_BACC;
            bms_pkg::ST_BACC: begin
                state_next = (axis_reg == 3'd5) ? bms_pkg::ST_DONE : bms_pkg::ST_BMUL;
            end
            bms_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bms_pkg::ST_IDLE;
                end
            end
            default: state_next = bms_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = {bank_reg, idx_reg[bms_pkg::IDX_W-1:0]};
        sc_start = 1'b0;
        unique case (state_reg)
            bms_pkg::ST_IDLE:  s_tready = 1'b1;
            bms_pkg::ST_READ:  rd_en    = 1'b1;
            bms_pkg::ST_START: sc_start = 1'b1;
            bms_pkg::ST_BREAD: begin
                rd_en   = 1'b1;
                rd_addr = {bank_reg, slot_reg};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bms_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // frame bookkeeping: close the frame on the last transaction, swap banks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_cnt_reg  <= '0;
            build_cnt_reg <= '0;
            bank_reg      <= 1'b0;
        end else if (state_reg == bms_pkg::ST_IDLE && s_acc && !s_tuser && s_tlast) begin
            prev_cnt_reg  <= build_cnt_reg;
            build_cnt_reg <= '0;
            bank_reg      <= ~bank_reg;
        end else if (state_reg == bms_pkg::ST_DONE && out_free) begin
            if (fend_reg) begin
                prev_cnt_reg  <= kept ? build_cnt_reg + 1'b1 : build_cnt_reg;
                build_cnt_reg <= '0;
                bank_reg      <= ~bank_reg;
            end else if (kept) begin
                build_cnt_reg <= build_cnt_reg + 1'b1;
            end
        end
    end

    // scan datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            bms_pkg::ST_IDLE: begin
                in_box_reg  <= s_tdata;
                res_box_reg <= s_tdata;
                fend_reg    <= s_tlast;
                idx_reg     <= '0;
                found_reg   <= 1'b0;
                slot_reg    <= '0;
            end
            bms_pkg::ST_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    dsq_reg[k] <= cabs[k][30:0];
                end
                sc_in_reg.num <= ext_num;
                sc_in_reg.den <= ext_den;
                sq_cnt_reg    <= '0;
                acc_reg       <= '0;
                if (entry_pruned) begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            bms_pkg::ST_SQ: begin
                sq_cnt_reg <= sq_cnt_reg + 2'd1;
                if (sq_cnt_reg != 2'd0) begin
                    acc_reg <= acc_reg + prod_reg[63:0];
                end
                // hand the full sum to the score unit before it starts
                if (sq_cnt_reg == 2'd3) begin
                    sc_in_reg.sq_sum <= acc_reg + prod_reg[63:0];
                end
            end
            bms_pkg::ST_CHECK: begin
                idx_reg <= idx_reg + 1'b1;
                if (entry_ok && (!found_reg || score < best_reg)) begin
                    found_reg <= 1'b1;
                    best_reg  <= score;
                    slot_reg  <= idx_reg[bms_pkg::IDX_W-1:0];
                end
            end
            bms_pkg::ST_BREAD: axis_reg <= '0;
            bms_pkg::ST_BACC: begin
                res_box_reg <= bms_pkg::box_set_axis(res_box_reg, axis_reg, blend_t[47:16]);
                axis_reg    <= axis_reg + 3'd1;
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == bms_pkg::ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == bms_pkg::ST_DONE && out_free) begin
            m_box_reg     <= res_box_reg;
            m_matched_reg <= found_reg;
            m_slot_reg    <= found_reg ? 6'(slot_reg) : 6'd0;
            m_kept_reg    <= kept;
            m_last_reg    <= fend_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_slot_reg, m_box_reg};
    assign m_tuser  = {m_kept_reg, m_matched_reg};
    assign m_tlast  = m_last_reg;

endmodule
